### design/grq_pkg.sv
// Shared widths, codes and reset values for the graph reachability query unit.
// Depends on nothing; used by graph_reachability_query_unit.
package grq_pkg;

   // Field widths of the request and response words
   localparam int ROW_W     = 16;  // adjacency row, one bit per destination vertex
   localparam int IDX_W     = 4;   // vertex index
   localparam int CNT_W     = 5;   // vertex count and walk length
   localparam int REQ_DATA_W = 32; // row_index, row_bits, source, dest, zero fill
   localparam int RSP_DATA_W = 8;  // connected, walk_length, zero fill

   // Default store depth
   localparam int MAX_VERTICES_DEF = 16;

   // Reset value of the vertex count register
   localparam logic [CNT_W-1:0] VC_RESET = 5'd16;

   // Request kinds carried on tuser
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

endpackage

### design/graph_reachability_query_unit.sv
// Graph reachability query unit: adjacency row store and Boolean row-power sequencer.
// Depends on grq_pkg for widths, request kinds and reset values.
//
// A row load is written as it is accepted. A query first reads the source row, then runs
// steps until the destination is reached or the walk length reaches n, the vertex count in use
// (the length reported runs 1..n, and is 1 when n is 0). Each further step reads m = min(n,16)
// rows through the single read port, then folds in the last row and checks again.
// The unit takes no new word while a query is in progress; a stalled response holds it.
// Reset (synchronous, active high) clears control, the reach vector and the count (to 16).
module graph_reachability_query_unit #(
   parameter int MAX_VERTICES = grq_pkg::MAX_VERTICES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // req_tdata: row_index[3:0], row_bits[19:4], source_vertex[23:20],
   //            dest_vertex[27:24], zero[31:28]
   input  logic [grq_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: action[0]
   input  logic                           req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rsp_tdata: connected[0], walk_length[5:1], zero[7:6]
   output logic [grq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration: vertex_count
   input  logic                           csr_we,
   input  logic [grq_pkg::CNT_W-1:0]      csr_wdata
);

   localparam int ROW_W = grq_pkg::ROW_W;
   localparam int IDX_W = grq_pkg::IDX_W;
   localparam int CNT_W = grq_pkg::CNT_W;
   localparam int AW    = $clog2(MAX_VERTICES);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0; // take a word
   localparam logic [2:0] S_FIRST  = 3'd1; // issue read of the source row
   localparam logic [2:0] S_FIRSTW = 3'd2; // source row returns
   localparam logic [2:0] S_CHECK  = 3'd3; // test destination bit and step bound
   localparam logic [2:0] S_SCAN   = 3'd4; // read rows 0..m-1, OR in the selected ones
   localparam logic [2:0] S_DRAIN  = 3'd5; // fold in the last row, close the step

   // unpack the request word
   logic [IDX_W-1:0] req_row_index;
   logic [ROW_W-1:0] req_row_bits;
   logic [IDX_W-1:0] req_source;
   logic [IDX_W-1:0] req_dest;

   assign req_row_index = req_tdata[IDX_W-1:0];
   assign req_row_bits  = req_tdata[IDX_W+ROW_W-1:IDX_W];
   assign req_source    = req_tdata[2*IDX_W+ROW_W-1:IDX_W+ROW_W];
   assign req_dest      = req_tdata[3*IDX_W+ROW_W-1:2*IDX_W+ROW_W];

   // registers
   logic [2:0]       state_ff,   state_in;
   logic [CNT_W-1:0] vc_ff,      vc_in;
   logic [IDX_W-1:0] src_ff,     src_in;
   logic [IDX_W-1:0] dst_ff,     dst_in;
   logic             src_ok_ff,  src_ok_in;
   logic [CNT_W-1:0] n_ff,       n_in;
   logic [CNT_W-1:0] m_ff,       m_in;
   logic [ROW_W-1:0] mask_ff,    mask_in;
   logic [ROW_W-1:0] reach_ff,   reach_in;
   logic [ROW_W-1:0] next_ff,    next_in;
   logic [CNT_W-1:0] steps_ff,   steps_in;
   logic [CNT_W-1:0] k_ff,       k_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_sel_ff,  rd_sel_in;
   logic [ROW_W-1:0] rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_conn_ff,  rsp_conn_in;
   logic [CNT_W-1:0] rsp_len_ff,   rsp_len_in;

   // memory control
   logic [ROW_W-1:0] adj_mem [MAX_VERTICES];
   logic             mem_we;
   logic [AW-1:0]    wr_addr;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;

   // working values
   logic             req_take;
   logic [CNT_W-1:0] n_cfg;
   logic [CNT_W-1:0] m_cfg;
   logic [ROW_W-1:0] mask_cfg;
   logic [ROW_W-1:0] acc;
   logic             finish;
   logic             rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(grq_pkg::RSP_DATA_W-CNT_W-1){1'b0}}, rsp_len_ff, rsp_conn_ff};
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // vertex count in use saturates at the store depth; the scan never passes the row width
   always_comb begin
      if (int'(vc_ff) > MAX_VERTICES) begin
         n_cfg = CNT_W'(MAX_VERTICES);
      end else begin
         n_cfg = vc_ff;
      end
      if (int'(n_cfg) > ROW_W) begin
         m_cfg = CNT_W'(ROW_W);
      end else begin
         m_cfg = n_cfg;
      end
      for (int j = 0; j < ROW_W; j++) begin
         mask_cfg[j] = (j < int'(n_cfg));
      end
   end

   // OR in the row that returned, if its bit was set in the reach vector
   assign acc    = next_ff | ((rd_pend_ff && rd_sel_ff) ? rd_data_ff : '0);
   // stop once the destination is reached or the walk is as long as the count
   assign finish = reach_ff[dst_ff] || (steps_ff >= n_ff);

   always_comb begin
      state_in     = state_ff;
      vc_in        = vc_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      src_ok_in    = src_ok_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      mask_in      = mask_ff;
      reach_in     = reach_ff;
      next_in      = acc;
      steps_in     = steps_ff;
      k_in         = k_ff;
      rd_pend_in   = 1'b0;
      rd_sel_in    = rd_sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_conn_in  = rsp_conn_ff;
      rsp_len_in   = rsp_len_ff;
      mem_we       = 1'b0;
      wr_addr      = AW'(req_row_index);
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (csr_we) begin
         vc_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_tuser == grq_pkg::ACT_LOAD) begin
                  // drop loads beyond the store
                  mem_we = (int'(req_row_index) < MAX_VERTICES);
               end else begin
                  src_in    = req_source;
                  dst_in    = req_dest;
                  src_ok_in = (int'(req_source) < int'(n_cfg));
                  n_in      = n_cfg;
                  m_in      = m_cfg;
                  mask_in   = mask_cfg;
                  state_in  = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(src_ff);
            state_in = S_FIRSTW;
         end
         S_FIRSTW: begin
            reach_in = src_ok_ff ? (rd_data_ff & mask_ff) : '0;
            steps_in = CNT_W'(1);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (finish) begin
               // hold here until the output register is free
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_conn_in  = reach_ff[dst_ff];
                  rsp_len_in   = steps_ff;
                  state_in     = S_IDLE;
               end
            end else begin
               next_in  = '0;
               k_in     = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en      = 1'b1;
            rd_addr    = AW'(k_ff);
            rd_pend_in = 1'b1;
            rd_sel_in  = reach_ff[k_ff[IDX_W-1:0]];
            k_in       = k_ff + CNT_W'(1);
            if (k_ff == m_ff - CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            reach_in = acc & mask_ff;
            steps_in = steps_ff + CNT_W'(1);
            state_in = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // adjacency row memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         adj_mem[wr_addr] <= req_row_bits;
      end
      if (rd_en) begin
         rd_data_ff <= adj_mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vc_ff        <= grq_pkg::VC_RESET;
         reach_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vc_ff        <= vc_in;
         reach_ff     <= reach_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      src_ok_ff   <= src_ok_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      mask_ff     <= mask_in;
      next_ff     <= next_in;
      steps_ff    <= steps_in;
      k_ff        <= k_in;
      rd_sel_ff   <= rd_sel_in;
      rsp_conn_ff <= rsp_conn_in;
      rsp_len_ff  <= rsp_len_in;
   end

   // no read may still be in flight when a new word is taken
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rd_pend_ff)
      else $error("read pending while idle");

   // the scan stays within the rows in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (k_ff < m_ff))
      else $error("row scan past vertex count");

   // a finished query lands in the output register and frees the unit
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && finish && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished query not delivered");

   // the walk never grows past a nonzero vertex count
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && n_ff != '0) |-> (steps_ff <= n_ff))
      else $error("walk length beyond vertex count");

   // the last row of a scan is always still to be folded in
   a_drain_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> rd_pend_ff)
      else $error("drain without returning row");

endmodule

### tb/tb_graph_reachability_query_unit.sv
// Self-checking testbench for graph_reachability_query_unit: row loads and reachability
// queries over several vertex counts and idle patterns, checked against a local walk model.
// Depends on grq_pkg and the graph_reachability_query_unit RTL only.
module tb_graph_reachability_query_unit;

   localparam int ROW_W       = grq_pkg::ROW_W;
   localparam int IDX_W       = grq_pkg::IDX_W;
   localparam int CNT_W       = grq_pkg::CNT_W;
   localparam int MAXV        = grq_pkg::MAX_VERTICES_DEF;
   localparam int SEGMENTS    = 12;   // random segments, one vertex count each
   localparam int SEG_WORDS   = 55;   // mixed words after each graph build
   localparam int SETTLE      = 6;    // quiet cycles before a register write
   localparam int TAIL_CYCLES = 300; // quiet cycles at the end, longer than the longest query

   // request word as it sits on req_tdata, lowest field last
   typedef struct packed {
      logic [3:0]       fill;
      logic [IDX_W-1:0] dest;
      logic [IDX_W-1:0] source;
      logic [ROW_W-1:0] bits;
      logic [IDX_W-1:0] row;
   } req_word_type;

   // response word as it sits on rsp_tdata
   typedef struct packed {
      logic [1:0]       fill;
      logic [CNT_W-1:0] walk_length;
      logic             connected;
   } answer_type;

   typedef enum int {SHAPE_CHAIN, SHAPE_SPARSE, SHAPE_DENSE, SHAPE_MIXED} shape_type;
   typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;

   // Adjacency store, vertex count and the queue of answers still owed by the unit
   class reach_checker;
      logic [ROW_W-1:0] rows [MAXV];
      logic [ROW_W-1:0] reach_vec;
      logic [CNT_W-1:0] order_reg;
      answer_type       pending_answers [$];
      int               fail_count;

      function new();
         foreach (rows[i]) rows[i] = '0;
         reach_vec  = '0;
         order_reg  = grq_pkg::VC_RESET;
         fail_count = 0;
      endfunction

      function void set_order(logic [CNT_W-1:0] value);
         order_reg = value;
      endfunction

      // Walk the source's row of the Boolean matrix powers until the destination
      // shows up or the length reaches the vertex count
      function answer_type walk_answer(logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst);
         int unsigned      used;
         int unsigned      steps;
         logic [ROW_W-1:0] mask;
         logic [ROW_W-1:0] nxt;
         answer_type       ans;
         used      = (order_reg > MAXV) ? MAXV : order_reg;
         mask      = ROW_W'((64'd1 << used) - 64'd1);
         reach_vec = (src < used) ? (rows[src] & mask) : '0;
         steps     = 1;
         while (!reach_vec[dst] && steps < used) begin
            nxt = '0;
            for (int k = 0; k < used; k++) begin
               if (reach_vec[k]) nxt |= rows[k];
            end
            reach_vec = nxt & mask;
            steps++;
         end
         ans             = '0;
         ans.connected   = reach_vec[dst];
         ans.walk_length = CNT_W'(steps);
         return ans;
      endfunction

      function void note_word(logic act, req_word_type w);
         if (act == grq_pkg::ACT_LOAD) begin
            rows[w.row] = w.bits;
         end else begin
            pending_answers.push_back(walk_answer(w.source, w.dest));
         end
      endfunction

      task report(string what, int got, int want);
         $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
         fail_count++;
      endtask

      task check_answer(answer_type got);
         answer_type want;
         if (pending_answers.size() == 0) begin
            report("response word with no query pending, walk_length", got.walk_length, 0);
            return;
         end
         want = pending_answers.pop_front();
         if (got.connected !== want.connected)
            report("connected", got.connected, want.connected);
         if (got.walk_length !== want.walk_length)
            report("walk_length", got.walk_length, want.walk_length);
      endtask
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [grq_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = grq_pkg::ACT_LOAD;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [grq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [CNT_W-1:0]               csr_wdata  = '0;

   int send_idle_pct = 0;   // chance in a hundred that the sender holds back a cycle
   int stall_pct     = 0;   // chance in a hundred that the receiver stalls a cycle
   int order_now     = 16;  // vertex count in use, saturated, for picking vertices

   reach_checker board = new();

   graph_reachability_query_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Receiver: stall at random per cycle, at the rate of the current pace
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: check the response before noting a new query taken at the same edge,
   // since that response always belongs to an earlier query
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_answer(rsp_tdata);
         if (req_tvalid && req_tready) board.note_word(req_tuser, req_tdata);
      end
   end

   // Present one word and hold it until taken; leave valid high so that a word
   // following straight on needs no second assignment in the same step
   task automatic send_word(input logic act, input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   // Loads carry random query fields and queries random row fields: the unit must ignore them
   task automatic load_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits);
      req_word_type w;
      w        = '0;
      w.row    = idx;
      w.bits   = bits;
      w.source = IDX_W'($urandom);
      w.dest   = IDX_W'($urandom);
      send_word(grq_pkg::ACT_LOAD, w);
   endtask

   task automatic ask(input logic [IDX_W-1:0] src, input logic [IDX_W-1:0] dst);
      req_word_type w;
      w        = '0;
      w.row    = IDX_W'($urandom);
      w.bits   = ROW_W'($urandom);
      w.source = src;
      w.dest   = dst;
      send_word(grq_pkg::ACT_QUERY, w);
   endtask

   // Drop valid and wait until every owed answer has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_answers.size() != 0) @(posedge clock);
   endtask

   // Write the vertex count only once the unit is idle
   task automatic write_order(input logic [CNT_W-1:0] value);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_order(value);
      order_now = (value > MAXV) ? MAXV : value;
   endtask

   function automatic logic [ROW_W-1:0] sparse_row();
      logic [ROW_W-1:0] bits;
      bits = ROW_W'(1) << $urandom_range(ROW_W-1);
      if ($urandom_range(1)) bits |= ROW_W'(1) << $urandom_range(ROW_W-1);
      return bits;
   endfunction

   // Mostly vertices inside the count, so that walks run long; the rest anywhere
   function automatic logic [IDX_W-1:0] pick_vertex();
      if (order_now > 0 && $urandom_range(99) < 85)
         return IDX_W'($urandom_range(order_now - 1));
      return IDX_W'($urandom);
   endfunction

   // Load all rows in shuffled order; a chain is a random Hamiltonian path, open or closed
   task automatic build_graph(input shape_type shape);
      int               perm [MAXV];
      int               j;
      int               t;
      logic [ROW_W-1:0] bits;
      foreach (perm[i]) perm[i] = i;
      for (int i = MAXV - 1; i > 0; i--) begin
         j       = $urandom_range(i);
         t       = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      for (int i = 0; i < MAXV; i++) begin
         case (shape)
            SHAPE_CHAIN: begin
               if (i < MAXV - 1) bits = ROW_W'(1) << perm[i+1];
               else bits = $urandom_range(1) ? ROW_W'(1) << perm[0] : '0;
            end
            SHAPE_SPARSE: bits = sparse_row();
            SHAPE_DENSE:  bits = ROW_W'($urandom);
            default: begin
               case ($urandom_range(2))
                  0:       bits = '0;
                  1:       bits = sparse_row();
                  default: bits = ROW_W'($urandom);
               endcase
            end
         endcase
         load_row(IDX_W'(perm[i]), bits);
      end
   endtask

   initial begin
      logic [CNT_W-1:0] order_plan [8];
      pace_type         pace;
      order_plan = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd17, 5'd8, 5'd5};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: a plain chain 0 -> 1 -> ... -> 15, with vertex 15 pointing everywhere,
      // so every row is written before the first query
      for (int i = 0; i < MAXV - 1; i++) load_row(IDX_W'(i), ROW_W'(1) << (i + 1));
      load_row(4'd15, 16'hFFFF);
      ask(4'd0, 4'd1);    // one step
      ask(4'd0, 4'd15);   // fifteen steps along the chain
      ask(4'd0, 4'd0);    // back to the start only at the last allowed step
      ask(4'd15, 4'd0);   // full row
      load_row(4'd15, 16'h0000);
      ask(4'd0, 4'd0);    // dead end: not connected, length at the count
      write_order(5'd0);  // no vertex in use
      ask(4'd0, 4'd0);
      write_order(5'd31); // count above the store saturates
      ask(4'd0, 4'd15);
      write_order(5'd4);  // columns beyond the count ignored
      ask(4'd3, 4'd0);
      ask(4'd0, 4'd9);    // destination beyond the count
      ask(4'd9, 4'd1);    // source beyond the count

      // Random: each segment sets a count, rebuilds the graph, then mixes reloads and queries
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         pace = pace_type'(seg % 4);
         write_order(seg < 8 ? order_plan[seg] : CNT_W'($urandom_range(1, MAXV)));
         case (pace)
            PACE_FREE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            PACE_SENDER:   begin send_idle_pct = 60; stall_pct = 0;  end
            PACE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 60; end
            default:       begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         build_graph(shape_type'((seg + seg / 4) % 4));
         repeat (SEG_WORDS) begin
            if ($urandom_range(99) < 25) begin
               load_row(IDX_W'($urandom),
                        $urandom_range(1) ? sparse_row() : ROW_W'($urandom));
            end else begin
               ask(pick_vertex(), pick_vertex());
            end
         end
      end

      // Wait out the last answers, then a query's worth of cycles for any stray word
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.fail_count == 0) begin
         $display("** graph_reachability_query_unit: PASSED **");
      end else begin
         $display("** graph_reachability_query_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #(64'd12_000_000);
      $display("** graph_reachability_query_unit: FAILED **");
      $finish;
   end

endmodule

### graph_reachability_query_unit.f
design/grq_pkg.sv
design/graph_reachability_query_unit.sv
tb/tb_graph_reachability_query_unit.sv
